FILE: rtl/round_robin_thread_picker_macros.svh
// assertion macros for the round-robin thread picker
// used by rrtp_ctrl and rrtp_dp; expects a clock i_clk and reset i_rst_n in scope
`ifndef ROUND_ROBIN_THREAD_PICKER_MACROS_SVH
`define ROUND_ROBIN_THREAD_PICKER_MACROS_SVH

// checked property, disabled while reset is held
`define RRTP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked property, also watched during reset
`define RRTP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/rrtp_pkg.sv
// shared types and constants of the round-robin thread picker
// no dependencies
package rrtp_pkg;

    localparam int THREADS_DEF = 16;
    localparam int CORES_DEF   = 4;
    localparam int EVENTS_DEF  = 16;

    // request kinds
    localparam logic [2:0] REQ_NEW     = 3'd0;
    localparam logic [2:0] REQ_EXIT    = 3'd1;
    localparam logic [2:0] REQ_WAIT    = 3'd2;
    localparam logic [2:0] REQ_SIGNAL  = 3'd3;
    localparam logic [2:0] REQ_UNBLOCK = 3'd4;
    localparam logic [2:0] REQ_RESCHED = 3'd5;

    // result status codes
    localparam logic [1:0] STS_DONE    = 2'd0;
    localparam logic [1:0] STS_NONE    = 2'd1;
    localparam logic [1:0] STS_PENDING = 2'd2;

    // slot states
    localparam logic [2:0] SL_FREE  = 3'd0;
    localparam logic [2:0] SL_IDLE  = 3'd1;
    localparam logic [2:0] SL_RUN   = 3'd2;
    localparam logic [2:0] SL_BLOCK = 3'd3;
    localparam logic [2:0] SL_DEAD  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FIN,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic fin;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_end;
    } t_sts;

endpackage

FILE: rtl/round_robin_thread_picker.sv
// top level of the round-robin thread picker
// depends on rrtp_pkg, rrtp_ctrl and rrtp_dp
//
// Thread slot scheduler with per-slot core affinity. One request item in, one result
// item out. Create, signal, unblock, wait on a pending event and ignored requests put
// their result in the output register straight after the execute state. Exit, wait and
// reschedule walk the slot table one slot per cycle from the starting slot until a
// runnable slot is found, at most THREADS slots, before the finish and output states.
// The single slot scan in the datapath sets how long these requests take. A new item is
// taken once the previous one has reached the output register; a stalled result holds
// the next one at the output stage.
module round_robin_thread_picker #(
    parameter int THREADS = rrtp_pkg::THREADS_DEF,
    parameter int CORES   = rrtp_pkg::CORES_DEF,
    parameter int EVENTS  = rrtp_pkg::EVENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // core_id, thread_id, affinity, event_id
    input  logic [2:0]  i_s_tuser,   // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // status, next_thread, switched, freed_mask
);

    rrtp_pkg::t_cmd w_cmd;
    rrtp_pkg::t_sts w_sts;
    logic [1:0]     w_status;
    logic [3:0]     w_next;
    logic           w_sw;
    logic [15:0]    w_freed;

    rrtp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    rrtp_dp #(
        .THREADS (THREADS),
        .CORES   (CORES),
        .EVENTS  (EVENTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_type    (i_s_tuser),
        .i_core_id     (i_s_tdata[1:0]),
        .i_thread_id   (i_s_tdata[5:2]),
        .i_affinity    (i_s_tdata[9:6]),
        .i_event_id    (i_s_tdata[13:10]),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_status      (w_status),
        .o_next_thread (w_next),
        .o_switched    (w_sw),
        .o_freed_mask  (w_freed)
    );

    // result packing
    assign o_m_tdata = {1'b0, w_freed, w_sw, w_next, w_status};

endmodule

FILE: rtl/rrtp_ctrl.sv
// sequencer of the round-robin thread picker: accept, execute, scan, finish, output
// depends on rrtp_pkg and round_robin_thread_picker_macros.svh
`include "round_robin_thread_picker_macros.svh"

module rrtp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rrtp_pkg::t_cmd o_cmd,
    input  rrtp_pkg::t_sts i_sts
);

    rrtp_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == rrtp_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrtp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            rrtp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = rrtp_pkg::S_EXEC;
                end
            end
            rrtp_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.need_scan ? rrtp_pkg::S_SCAN : rrtp_pkg::S_OUT;
            end
            rrtp_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_end) n_state = rrtp_pkg::S_FIN;
            end
            rrtp_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = rrtp_pkg::S_OUT;
            end
            rrtp_pkg::S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = rrtp_pkg::S_IDLE;
                end
            end
            default: n_state = rrtp_pkg::S_IDLE;
        endcase
    end

    // checks
    `RRTP_ASSERT(a_accept_exec, (i_in_valid && o_in_ready) |=> (r_state == rrtp_pkg::S_EXEC), "accepted item not executed")
    `RRTP_ASSERT(a_load_valid, o_cmd.out_load |=> r_out_valid, "result load lost")
    `RRTP_ASSERT(a_scan_fin, ((r_state == rrtp_pkg::S_SCAN) && i_sts.scan_end) |=> (r_state == rrtp_pkg::S_FIN), "scan end missed")

endmodule

FILE: rtl/rrtp_dp.sv
// datapath of the round-robin thread picker: slot table, event flags, scan unit, result
// depends on rrtp_pkg and round_robin_thread_picker_macros.svh
`include "round_robin_thread_picker_macros.svh"

module rrtp_dp #(
    parameter int THREADS = rrtp_pkg::THREADS_DEF,
    parameter int CORES   = rrtp_pkg::CORES_DEF,
    parameter int EVENTS  = rrtp_pkg::EVENTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [2:0]     i_req_type,
    input  logic [1:0]     i_core_id,
    input  logic [3:0]     i_thread_id,
    input  logic [3:0]     i_affinity,
    input  logic [3:0]     i_event_id,
    input  rrtp_pkg::t_cmd i_cmd,
    output rrtp_pkg::t_sts o_sts,
    output logic [1:0]     o_status,
    output logic [3:0]     o_next_thread,
    output logic           o_switched,
    output logic [15:0]    o_freed_mask
);

    localparam int TW = $clog2(THREADS);
    localparam int CW = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int EW = (EVENTS > 1) ? $clog2(EVENTS) : 1;

    // latched request
    logic [2:0] r_req;
    logic [1:0] r_core;
    logic [3:0] r_tid;
    logic [3:0] r_aff;
    logic [3:0] r_ev;

    // slot table and events
    logic [2:0]    r_sstate [THREADS];
    logic [3:0]    r_saff   [THREADS];
    logic [3:0]    r_swev   [THREADS];
    logic          r_shas   [THREADS];
    logic [EVENTS-1:0] r_pend;
    logic [TW-1:0] r_cact   [CORES];

    // scan and result
    logic [TW-1:0] r_idx;
    logic [TW-1:0] r_cnt;
    logic          r_found;
    logic [TW-1:0] r_pick;
    logic [1:0]    r_res_st;
    logic [3:0]    r_res_nxt;
    logic          r_res_sw;
    logic [15:0]   r_freed;
    logic [1:0]    r_out_st;
    logic [3:0]    r_out_nxt;
    logic          r_out_sw;
    logic [15:0]   r_out_freed;

    logic [CW+1:0] w_cext;
    logic [CW-1:0] w_cidx;
    logic          w_core_ok;
    logic          w_req_ok;
    logic [TW-1:0] w_act;
    logic [TW+3:0] w_act_ext;
    logic [TW+3:0] w_tid_ext;
    logic [TW-1:0] w_tid;
    logic          w_tid_ok;
    logic [EW+3:0] w_ev_ext;
    logic [EW-1:0] w_ev;
    logic          w_ev_ok;
    logic [2:0]    w_act_st;
    logic [2:0]    w_cur_st;
    logic [EW+3:0] w_cur_ev_ext;
    logic [EW-1:0] w_cur_ev;
    logic          w_hit_idle;
    logic          w_hit_block;
    logic [TW+3:0] w_idx_ext;
    logic [TW+3:0] w_pick_ext;

    // index decoding
    assign w_cext    = {{CW{1'b0}}, r_core};
    assign w_cidx    = w_cext[CW-1:0];
    assign w_core_ok = ({30'd0, r_core} < CORES);
    assign w_req_ok  = (r_req <= rrtp_pkg::REQ_RESCHED);
    assign w_act     = w_core_ok ? r_cact[w_cidx] : '0;
    assign w_act_ext = {4'd0, w_act};
    assign w_tid_ext = {{TW{1'b0}}, r_tid};
    assign w_tid     = w_tid_ext[TW-1:0];
    assign w_tid_ok  = ({28'd0, r_tid} < THREADS);
    assign w_ev_ext  = {{EW{1'b0}}, r_ev};
    assign w_ev      = w_ev_ext[EW-1:0];
    assign w_ev_ok   = ({28'd0, r_ev} < EVENTS);
    assign w_act_st  = r_sstate[w_act];

    // current scan slot
    assign w_cur_st     = r_sstate[r_idx];
    assign w_cur_ev_ext = {{EW{1'b0}}, r_swev[r_idx]};
    assign w_cur_ev     = w_cur_ev_ext[EW-1:0];
    assign w_hit_idle   = (w_cur_st == rrtp_pkg::SL_IDLE) && r_saff[r_idx][r_core];
    assign w_hit_block  = (w_cur_st == rrtp_pkg::SL_BLOCK) && r_shas[r_idx] && r_pend[w_cur_ev];
    assign w_idx_ext    = {4'd0, r_idx};
    assign w_pick_ext   = {4'd0, r_pick};

    // status to controller
    always_comb begin
        o_sts.need_scan = 1'b0;
        if (w_core_ok && w_req_ok) begin
            case (r_req)
                rrtp_pkg::REQ_EXIT, rrtp_pkg::REQ_RESCHED: o_sts.need_scan = 1'b1;
                rrtp_pkg::REQ_WAIT: o_sts.need_scan = w_ev_ok && !r_pend[w_ev];
                default: o_sts.need_scan = 1'b0;
            endcase
        end
        o_sts.scan_end = w_hit_idle || w_hit_block || ({{(32-TW){1'b0}}, r_cnt} == THREADS - 1);
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_core <= i_core_id;
            r_tid  <= i_thread_id;
            r_aff  <= i_affinity;
            r_ev   <= i_event_id;
        end
    end

    // slot table, events, scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < THREADS; k++) begin
                r_sstate[k] <= (k < CORES) ? rrtp_pkg::SL_RUN : rrtp_pkg::SL_FREE;
                r_saff[k]   <= (k < CORES) ? 4'(1 << k) : 4'd0;
                r_swev[k]   <= 4'd0;
                r_shas[k]   <= 1'b0;
            end
            for (int k = 0; k < CORES; k++) begin
                r_cact[k] <= (k < THREADS) ? TW'(k) : '0;
            end
            r_pend  <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.exec) begin
            r_cnt     <= '0;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_freed   <= '0;
            r_res_st  <= rrtp_pkg::STS_DONE;
            r_res_nxt <= w_act_ext[3:0];
            r_res_sw  <= 1'b0;
            if (!(w_core_ok && w_req_ok)) begin
                r_res_nxt <= 4'd0;
            end else begin
                case (r_req)
                    rrtp_pkg::REQ_NEW: begin
                        if (w_tid_ok && r_sstate[w_tid] == rrtp_pkg::SL_FREE) begin
                            r_sstate[w_tid] <= rrtp_pkg::SL_IDLE;
                            r_saff[w_tid]   <= r_aff;
                            r_swev[w_tid]   <= 4'd0;
                            r_shas[w_tid]   <= 1'b0;
                        end
                    end
                    rrtp_pkg::REQ_EXIT: begin
                        if (w_act_st != rrtp_pkg::SL_FREE) r_sstate[w_act] <= rrtp_pkg::SL_DEAD;
                    end
                    rrtp_pkg::REQ_WAIT: begin
                        if (w_ev_ok && r_pend[w_ev]) begin
                            r_pend[w_ev] <= 1'b0;
                            r_res_st     <= rrtp_pkg::STS_PENDING;
                        end else if (w_ev_ok && (w_act_st == rrtp_pkg::SL_IDLE ||
                                                 w_act_st == rrtp_pkg::SL_RUN)) begin
                            r_sstate[w_act] <= rrtp_pkg::SL_BLOCK;
                            r_swev[w_act]   <= r_ev;
                            r_shas[w_act]   <= 1'b1;
                        end
                    end
                    rrtp_pkg::REQ_SIGNAL: begin
                        if (w_ev_ok) r_pend[w_ev] <= 1'b1;
                    end
                    rrtp_pkg::REQ_UNBLOCK: begin
                        if (w_tid_ok && r_sstate[w_tid] == rrtp_pkg::SL_BLOCK) begin
                            r_sstate[w_tid] <= rrtp_pkg::SL_IDLE;
                            r_shas[w_tid]   <= 1'b0;
                        end
                    end
                    rrtp_pkg::REQ_RESCHED: begin
                        // resume after the active slot only if it is still live
                        if ((w_act_st == rrtp_pkg::SL_IDLE || w_act_st == rrtp_pkg::SL_RUN) &&
                            ({{(32-TW){1'b0}}, w_act} != THREADS - 1))
                            r_idx <= w_act + 1'b1;
                    end
                    default: r_res_nxt <= 4'd0;
                endcase
            end
        end else if (i_cmd.scan) begin
            r_cnt <= r_cnt + 1'b1;
            r_idx <= ({{(32-TW){1'b0}}, r_idx} == THREADS - 1) ? '0 : r_idx + 1'b1;
            if (w_cur_st == rrtp_pkg::SL_DEAD) begin
                r_sstate[r_idx] <= rrtp_pkg::SL_FREE;
                r_shas[r_idx]   <= 1'b0;
                if (w_idx_ext[TW+3:4] == '0) r_freed[w_idx_ext[3:0]] <= 1'b1;
            end else if (w_hit_idle) begin
                r_found <= 1'b1;
                r_pick  <= r_idx;
            end else if (w_hit_block) begin
                r_pend[w_cur_ev] <= 1'b0;
                r_found          <= 1'b1;
                r_pick           <= r_idx;
            end
        end else if (i_cmd.fin) begin
            if (r_found) begin
                if (w_act_st == rrtp_pkg::SL_RUN) r_sstate[w_act] <= rrtp_pkg::SL_IDLE;
                r_sstate[r_pick] <= rrtp_pkg::SL_RUN;
                r_shas[r_pick]   <= 1'b0;
                r_cact[w_cidx]   <= r_pick;
                r_res_st         <= rrtp_pkg::STS_DONE;
                r_res_nxt        <= w_pick_ext[3:0];
                r_res_sw         <= (r_pick != w_act);
            end else begin
                r_res_st  <= rrtp_pkg::STS_NONE;
                r_res_nxt <= w_act_ext[3:0];
                r_res_sw  <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_st    <= r_res_st;
            r_out_nxt   <= r_res_nxt;
            r_out_sw    <= r_res_sw;
            r_out_freed <= r_freed;
        end
    end

    assign o_status      = r_out_st;
    assign o_next_thread = r_out_nxt;
    assign o_switched    = r_out_sw;
    assign o_freed_mask  = r_out_freed;

    // checks
    `RRTP_ASSERT(a_fin_found, (i_cmd.fin && r_found) |=> (r_sstate[$past(r_pick)] == rrtp_pkg::SL_RUN), "picked slot not running")
    `RRTP_ASSERT(a_one_cmd, $onehot0(i_cmd), "more than one command at once")
    `RRTP_ASSERT(a_idle_hit, (i_cmd.scan && w_hit_idle) |=> r_found, "idle slot hit not recorded")

endmodule
